// ===== design/akvm_pkg.sv =====
// Package for the key-value map: item structs, request and status codes, chain token.
`timescale 1ns / 1ps

package akvm_pkg;

    localparam int KEY_WIDTH     = 32;
    localparam int VALUE_WIDTH   = 32;
    localparam int KIND_WIDTH    = 3;
    localparam int STATUS_WIDTH  = 2;
    localparam int COUNT_WIDTH   = 7;
    localparam int CAPACITY_DEF  = 64;

    localparam logic [KIND_WIDTH-1:0] KIND_ACCESS = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_ERASE  = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_PEEK   = 3'd4;

    localparam logic [STATUS_WIDTH-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_ABSENT   = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  result_value;
        logic [STATUS_WIDTH-1:0] status;
        logic [COUNT_WIDTH-1:0]  entry_count;
    } t_out_item;

    // Request token walking down the cell row.
    typedef struct packed {
        logic                   valid;
        logic [KIND_WIDTH-1:0]  kind;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
        logic                   found;     // key matched or was appended
        logic                   inserted;  // appended by this request
        logic                   shift;     // erase: cells pull from right neighbor
        logic [VALUE_WIDTH-1:0] rvalue;
    } t_token;

endpackage

// ===== design/akvm_cell.sv =====
// One slot of the map: holds a key and value and processes the passing token.
`timescale 1ns / 1ps

module akvm_cell
    import akvm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_token                 i_tok,
    input  logic [CW-1:0]          i_count,
    input  logic [KEY_WIDTH-1:0]   i_nbr_key,
    input  logic [VALUE_WIDTH-1:0] i_nbr_value,
    output t_token                 o_tok,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [KEY_WIDTH-1:0]   n_key;
    logic [VALUE_WIDTH-1:0] n_value;
    t_token                 r_tok;
    t_token                 n_tok;

    logic searchable;
    logic in_use;
    logic is_tail;
    logic match;
    logic append;

    always_comb begin
        searchable = (i_tok.kind == KIND_ACCESS) || (i_tok.kind == KIND_WRITE) ||
                     (i_tok.kind == KIND_ERASE)  || (i_tok.kind == KIND_PEEK);
        in_use     = i_count > CW'(IDX);
        is_tail    = i_count == CW'(IDX);
        match      = i_tok.valid && !i_tok.found && searchable && in_use &&
                     (r_key == i_tok.key);
        // first free slot reached with no match: append
        append     = i_tok.valid && !i_tok.found && is_tail &&
                     ((i_tok.kind == KIND_ACCESS) || (i_tok.kind == KIND_WRITE));

        n_tok   = i_tok;
        n_key   = r_key;
        n_value = r_value;

        if (match) begin
            n_tok.found = 1'b1;
            if (i_tok.kind == KIND_WRITE) begin
                n_value     = i_tok.value;
                n_tok.rvalue = i_tok.value;
            end else begin
                n_tok.rvalue = r_value;
            end
            if (i_tok.kind == KIND_ERASE) begin
                n_tok.shift = 1'b1;
                n_key       = i_nbr_key;
                n_value     = i_nbr_value;
            end
        end else if (i_tok.valid && i_tok.shift) begin
            // close the gap; slots past the count take don't-care data
            n_key   = i_nbr_key;
            n_value = i_nbr_value;
        end else if (append) begin
            n_tok.found    = 1'b1;
            n_tok.inserted = 1'b1;
            n_key          = i_tok.key;
            if (i_tok.kind == KIND_WRITE) begin
                n_value      = i_tok.value;
                n_tok.rvalue = i_tok.value;
            end else begin
                n_value      = '0;
                n_tok.rvalue = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ===== design/array_key_value_map.sv =====
// Top level of the key-value map: request injection, cell row and result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------
//  request   | start in, busy out        | i_req  (kind, key, value)
//  result    | o_strobe out, one cycle   | o_rsp  (result_value, status, entry_count)
//
// A request transfer enters slot 0 and its token advances one cell per cycle; the
// result strobes once the token has passed the last cell and the result register.
// busy drops in the strobe cycle, so the next request can transfer right then;
// a new request is not taken while the previous one is still in the cell row.
// Synchronous active-low reset empties the map; slot contents are not cleared.
// The receiver cannot stall; o_strobe marks each result for exactly one cycle.
`timescale 1ns / 1ps

module array_key_value_map
    import akvm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_req,
    output logic      o_strobe,
    output t_out_item o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                   r_busy;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_strobe;
    t_out_item              r_rsp;
    t_out_item              n_rsp;

    t_token                 w_tok   [0:CAPACITY];
    logic [KEY_WIDTH-1:0]   w_key   [0:CAPACITY-1];
    logic [VALUE_WIDTH-1:0] w_value [0:CAPACITY-1];

    logic   accept;
    t_token fin;

    assign accept = start && !r_busy;

    always_comb begin
        w_tok[0].valid    = accept;
        w_tok[0].kind     = i_req.kind;
        w_tok[0].key      = i_req.key;
        w_tok[0].value    = i_req.value;
        w_tok[0].found    = 1'b0;
        w_tok[0].inserted = 1'b0;
        w_tok[0].shift    = 1'b0;
        w_tok[0].rvalue   = '0;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_WIDTH-1:0]   nbr_key;
            logic [VALUE_WIDTH-1:0] nbr_value;
            if (g == CAPACITY - 1) begin : g_last
                assign nbr_key   = w_key[g];
                assign nbr_value = w_value[g];
            end else begin : g_mid
                assign nbr_key   = w_key[g+1];
                assign nbr_value = w_value[g+1];
            end
            akvm_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok       (w_tok[g]),
                .i_count     (r_count),
                .i_nbr_key   (nbr_key),
                .i_nbr_value (nbr_value),
                .o_tok       (w_tok[g+1]),
                .o_key       (w_key[g]),
                .o_value     (w_value[g])
            );
        end
    endgenerate

    assign fin = w_tok[CAPACITY];

    always_comb begin
        n_count            = r_count;
        n_rsp.result_value = '0;
        n_rsp.status       = ST_ABSENT;
        case (fin.kind)
            KIND_ACCESS, KIND_WRITE: begin
                if (fin.found) begin
                    n_rsp.result_value = fin.rvalue;
                    if (fin.inserted) begin
                        n_rsp.status = ST_INSERTED;
                        n_count      = r_count + CW'(1);
                    end else begin
                        n_rsp.status = ST_FOUND;
                    end
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            KIND_ERASE: begin
                if (fin.found) begin
                    n_rsp.status = ST_FOUND;
                    n_count      = r_count - CW'(1);
                end
            end
            KIND_CLEAR: begin
                n_rsp.status = ST_FOUND;
                n_count      = '0;
            end
            KIND_PEEK: begin
                if (fin.found) begin
                    n_rsp.status       = ST_FOUND;
                    n_rsp.result_value = fin.rvalue;
                end
            end
            default: begin
                n_rsp.status = ST_ABSENT;
            end
        endcase
        n_rsp.entry_count = COUNT_WIDTH'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (fin.valid) begin
            r_rsp <= n_rsp;
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= fin.valid;
            if (fin.valid) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (accept) begin
                r_busy <= 1'b1;
            end
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== dv/testbench.sv =====
// Testbench for array_key_value_map: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import akvm_pkg::*;

    localparam int MAP_DEPTH     = CAPACITY_DEF;
    localparam int KEY_POOL      = 80;    // a bit above the depth so the table fills up
    localparam int PHASE_ITEMS   = 633;
    localparam int GROW_ITEMS    = 260;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = MAP_DEPTH + 16;
    localparam int REPORT_LIMIT  = 10;

    // request kinds the block treats as no-ops
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_C = 3'd7;

    class kv_map_scoreboard;
        logic [KEY_WIDTH-1:0]   key_tab [MAP_DEPTH];
        logic [VALUE_WIDTH-1:0] val_tab [MAP_DEPTH];
        int unsigned            used;
        t_out_item              lookups_due [$];
        int unsigned            mismatches;
        int unsigned            requests;
        int unsigned            peak_used;
        int unsigned            status_seen [4];

        function new();
            used       = 0;
            mismatches = 0;
            requests   = 0;
            peak_used  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int slot_of(logic [KEY_WIDTH-1:0] key);
            for (int i = 0; i < used; i++) begin
                if (key_tab[i] == key) return i;
            end
            return -1;
        endfunction

        // Apply one accepted request to the shadow table and queue its response.
        function void note_request(t_in_item req);
            t_out_item rsp;
            int        slot;
            rsp.result_value = '0;
            rsp.status       = ST_ABSENT;
            case (req.kind)
                KIND_ACCESS, KIND_WRITE: begin
                    slot = slot_of(req.key);
                    if (slot >= 0) begin
                        if (req.kind == KIND_WRITE) val_tab[slot] = req.value;
                        rsp.result_value = val_tab[slot];
                        rsp.status       = ST_FOUND;
                    end else if (used >= MAP_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        key_tab[used]    = req.key;
                        val_tab[used]    = (req.kind == KIND_WRITE) ? req.value : '0;
                        rsp.result_value = val_tab[used];
                        rsp.status       = ST_INSERTED;
                        used++;
                    end
                end
                KIND_ERASE: begin
                    slot = slot_of(req.key);
                    if (slot >= 0) begin
                        used--;
                        key_tab[slot] = key_tab[used];
                        val_tab[slot] = val_tab[used];
                        rsp.status    = ST_FOUND;
                    end
                end
                KIND_CLEAR: begin
                    used       = 0;
                    rsp.status = ST_FOUND;
                end
                KIND_PEEK: begin
                    slot = slot_of(req.key);
                    if (slot >= 0) begin
                        rsp.result_value = val_tab[slot];
                        rsp.status       = ST_FOUND;
                    end
                end
                default: begin
                end
            endcase
            rsp.entry_count = COUNT_WIDTH'(used);
            requests++;
            status_seen[rsp.status]++;
            if (used > peak_used) peak_used = used;
            lookups_due.push_back(rsp);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (lookups_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result with no request pending: value=%h status=%0d count=%0d",
                             got.result_value, got.status, got.entry_count);
                return;
            end
            want = lookups_due.pop_front();
            if (got.result_value !== want.result_value || got.status !== want.status ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"ERROR: expected value=%h status=%0d count=%0d, ",
                              "got value=%h status=%0d count=%0d"},
                             want.result_value, want.status, want.entry_count,
                             got.result_value, got.status, got.entry_count);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_req;
    logic      o_strobe;
    t_out_item o_rsp;

    kv_map_scoreboard       sb;
    logic [KEY_WIDTH-1:0]   key_pool [KEY_POOL];
    int unsigned            idle_pct;
    int unsigned            stall_cycles;

    array_key_value_map #(
        .CAPACITY (MAP_DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // transfer monitor: results first, the new request goes to the back of the queue anyway
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_rsp);
            if (start && !busy) sb.note_request(i_req);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic t_in_item req_of(logic [KIND_WIDTH-1:0] kind,
                                        logic [KEY_WIDTH-1:0] key,
                                        logic [VALUE_WIDTH-1:0] value);
        t_in_item req;
        req.kind  = kind;
        req.key   = key;
        req.value = value;
        return req;
    endfunction

    // Growth mode favors inserts so the table reaches capacity; churn mixes erases and clears.
    function automatic t_in_item random_request(bit grow);
        t_in_item    req;
        int unsigned pick;
        pick = $urandom_range(99);
        if (grow) begin
            if (pick < 40)      req.kind = KIND_WRITE;
            else if (pick < 70) req.kind = KIND_ACCESS;
            else if (pick < 88) req.kind = KIND_PEEK;
            else if (pick < 97) req.kind = KIND_ERASE;
            else                req.kind = KIND_WIDTH'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        end else begin
            if (pick < 25)      req.kind = KIND_WRITE;
            else if (pick < 45) req.kind = KIND_ACCESS;
            else if (pick < 68) req.kind = KIND_PEEK;
            else if (pick < 93) req.kind = KIND_ERASE;
            else if (pick < 96) req.kind = KIND_CLEAR;
            else                req.kind = KIND_WIDTH'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        end
        if ($urandom_range(9) == 0) req.key = $urandom;
        else                        req.key = key_pool[$urandom_range(KEY_POOL - 1)];
        pick = $urandom_range(19);
        if (pick == 0)      req.value = '0;
        else if (pick == 1) req.value = '1;
        else                req.value = $urandom;
        return req;
    endfunction

    task automatic send_request(t_in_item req);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_req <= req;
            end
            @(posedge i_clk);
            taken = start && !busy;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.lookups_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_item directed [$];
        int unsigned sweep_idle [3];

        start    = 1'b0;
        i_req    = '0;
        i_rst_n  = 1'b0;
        idle_pct = 36;
        sb       = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty-table lookups, insert/update, no-op kinds, erase with and without
        // the last-entry move, clear on occupied and empty tables, bit extremes
        directed.push_back(req_of(KIND_PEEK,   32'h0000_0000, 32'h1234_5678));
        directed.push_back(req_of(KIND_ERASE,  32'h0000_0005, 32'h0000_0000));
        directed.push_back(req_of(KIND_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF));
        directed.push_back(req_of(KIND_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(req_of(KIND_WRITE,  32'h0000_0000, 32'hA5A5_A5A5));
        directed.push_back(req_of(KIND_ACCESS, 32'h0000_0000, 32'h0000_0000));
        directed.push_back(req_of(KIND_PEEK,   32'hFFFF_FFFF, 32'h0000_0000));
        directed.push_back(req_of(KIND_WRITE,  32'h0000_0001, 32'h0000_0000));
        directed.push_back(req_of(KIND_SPARE_A, 32'h0000_0000, 32'hFFFF_FFFF));
        directed.push_back(req_of(KIND_SPARE_B, 32'hFFFF_FFFF, 32'h0000_0000));
        directed.push_back(req_of(KIND_SPARE_C, 32'h0000_0001, 32'h5A5A_5A5A));
        directed.push_back(req_of(KIND_ERASE,  32'h0000_0000, 32'h0000_0000));
        directed.push_back(req_of(KIND_PEEK,   32'h0000_0001, 32'h0000_0000));
        directed.push_back(req_of(KIND_PEEK,   32'h0000_0000, 32'h0000_0000));
        directed.push_back(req_of(KIND_ERASE,  32'h0000_0001, 32'h0000_0000));
        directed.push_back(req_of(KIND_WRITE,  32'h8000_0000, 32'h8000_0001));
        directed.push_back(req_of(KIND_CLEAR,  32'h0000_0000, 32'h0000_0000));
        directed.push_back(req_of(KIND_PEEK,   32'hFFFF_FFFF, 32'h0000_0000));
        directed.push_back(req_of(KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(req_of(KIND_WRITE,  32'h5555_5555, 32'hAAAA_AAAA));
        directed.push_back(req_of(KIND_WRITE,  32'hAAAA_AAAA, 32'h5555_5555));
        directed.push_back(req_of(KIND_ERASE,  32'h5555_5555, 32'h0000_0000));
        directed.push_back(req_of(KIND_PEEK,   32'hAAAA_AAAA, 32'h0000_0000));
        foreach (directed[i]) send_request(directed[i]);
        wait_drained();

        sweep_idle[0] = 36;
        sweep_idle[1] = 69;
        sweep_idle[2] = 0;
        foreach (sweep_idle[p]) begin
            idle_pct = sweep_idle[p];
            send_request(req_of(KIND_CLEAR, '0, '0));
            for (int n = 1; n < PHASE_ITEMS; n++) send_request(random_request(n < GROW_ITEMS));
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.lookups_due.size() != 0) begin
            $display("ERROR: %0d results never arrived", sb.lookups_due.size());
            sb.mismatches++;
        end
        $display("Ran %0d requests, peak occupancy %0d of %0d, %0d mismatches",
                 sb.requests, sb.peak_used, MAP_DEPTH, sb.mismatches);
        $display("Outcomes: found %0d, inserted %0d, absent %0d, rejected when full %0d",
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_INSERTED],
                 sb.status_seen[ST_ABSENT], sb.status_seen[ST_FULL]);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/akvm_pkg.sv
design/akvm_cell.sv
design/array_key_value_map.sv
dv/testbench.sv
